/* sv/csf_pkg.sv */
package csf_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned LenW    = 5;
  localparam int unsigned CapW    = 11;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 64;

  localparam logic [CfgIdxW-1:0] CfgQueryLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgQueryHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgQueryLen  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgCapacity  = 2'd3;

  localparam logic [CapW-1:0]  CapReset   = 11'd1024;
  localparam logic [CharW-1:0] UpperFirst = 8'h41;
  localparam logic [CharW-1:0] UpperLast  = 8'h5A;
  localparam logic [CharW-1:0] CaseOffset = 8'h20;

  typedef struct packed {
    logic [CharW-1:0] title_char;
    logic             char_present;
    logic             end_of_title;
    logic             last_title;
  } in_req_t;

  typedef struct packed {
    logic [IndexW-1:0] title_index;
    logic              title_matched;
    logic              title_kept;
    logic [IndexW-1:0] result_slot;
    logic [CapW-1:0]   kept_total;
    logic              list_done;
    logic              search_active;
  } out_res_t;

  typedef struct packed {
    logic fire;
    logic matched;
    logic last;
    logic active;
  } title_end_t;

  function automatic logic [CharW-1:0] fold_lower(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c inside {[UpperFirst:UpperLast]}) begin
      r = c + CaseOffset;
    end
    return r;
  endfunction

endpackage

/* sv/case_insensitive_substring_filter.sv */
// A title's result appears on the output in the cycle after its last item is accepted.
// Throughput: one item per cycle while in_stall_o is low; the Shift-And row of cells advances once per character.
// A result waiting under stall blocks new items only while the output register is held.
// Reset clears matcher cells, found flag, counters and output valid; the query resets
// to empty and the capacity to 1024. No clearing pass is needed after reset.
module case_insensitive_substring_filter #(
  parameter int unsigned QUERY_MAX = 16,
  parameter int unsigned LIST_MAX  = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  csf_pkg::in_req_t            in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output csf_pkg::out_res_t           out_res_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [csf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [csf_pkg::CfgW-1:0]    cfg_data_i
);
  import csf_pkg::*;

  logic [CfgW-1:0]      qlow_q, qhigh_q;
  logic [LenW-1:0]      qlen_q;
  logic [CapW-1:0]      cap_q;
  logic [2*CfgW-1:0]    qchars;
  logic [LenW-1:0]      len_eff;
  logic [CharW-1:0]     char_f;
  logic [QUERY_MAX-1:0] match_bits, hit_bits, tail_sel, en_bits;
  logic                 in_acc, step, clear, found_hit, matched;
  logic                 found_q, found_d;
  logic                 out_valid_q, out_valid_d;
  out_res_t             out_res_q, res_calc;
  title_end_t           title_end;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlow_q  <= '0;
      qhigh_q <= '0;
      qlen_q  <= '0;
      cap_q   <= CapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgQueryLow:  qlow_q  <= cfg_data_i;
        CfgQueryHigh: qhigh_q <= cfg_data_i;
        CfgQueryLen:  qlen_q  <= cfg_data_i[LenW-1:0];
        CfgCapacity:  cap_q   <= cfg_data_i[CapW-1:0];
        default: ;
      endcase
    end
  end

  assign qchars  = {qhigh_q, qlow_q};
  assign len_eff = (qlen_q > LenW'(QUERY_MAX)) ? LenW'(QUERY_MAX) : qlen_q;
  assign char_f  = fold_lower(in_req_i.title_char);

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign step       = in_acc && in_req_i.char_present && (len_eff != '0);
  assign clear      = in_acc && in_req_i.end_of_title;

  for (genvar g = 0; g < QUERY_MAX; g++) begin : g_cell
    logic prev;
    if (g == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = match_bits[g-1];
    end
    assign en_bits[g]  = LenW'(g) < len_eff;
    assign tail_sel[g] = len_eff == LenW'(g + 1);

    csf_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .prev_i   (prev),
      .enable_i (en_bits[g]),
      .qchar_i  (fold_lower(qchars[CharW*g +: CharW])),
      .char_i   (char_f),
      .step_i   (step),
      .clear_i  (clear),
      .hit_o    (hit_bits[g]),
      .match_o  (match_bits[g])
    );
  end

  assign found_hit = step && |(hit_bits & tail_sel);
  assign matched   = (len_eff == '0) || found_q || found_hit;

  always_comb begin
    found_d = found_q;
    if (clear) begin
      found_d = 1'b0;
    end else if (found_hit) begin
      found_d = 1'b1;
    end
  end

  always_comb begin
    title_end.fire    = clear;
    title_end.matched = matched;
    title_end.last    = in_req_i.last_title;
    title_end.active  = len_eff != '0;
  end

  csf_tally #(
    .LIST_MAX (LIST_MAX)
  ) u_tally (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .end_i      (title_end),
    .capacity_i (cap_q),
    .res_o      (res_calc)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (clear) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) begin
      out_res_q <= res_calc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> out_valid_o)
    else $error("title end did not produce a result");

  a_end_clears_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (match_bits == '0) && !found_q)
    else $error("matcher not cleared at title end");

  a_kept_implies_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.title_kept |-> out_res_o.title_matched)
    else $error("kept title without a match");

  a_kept_slot_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.title_kept |->
      out_res_o.kept_total[IndexW-1:0] == out_res_o.result_slot + IndexW'(1))
    else $error("kept total does not follow result slot");

endmodule

/* sv/csf_cell.sv */
module csf_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      prev_i,
  input  logic                      enable_i,
  input  logic [csf_pkg::CharW-1:0] qchar_i,
  input  logic [csf_pkg::CharW-1:0] char_i,
  input  logic                      step_i,
  input  logic                      clear_i,
  output logic                      hit_o,
  output logic                      match_o
);
  import csf_pkg::*;

  logic match_q, match_d;

  assign hit_o = prev_i && enable_i && (qchar_i == char_i);

  always_comb begin
    match_d = match_q;
    if (clear_i) begin
      match_d = 1'b0;
    end else if (step_i) begin
      match_d = hit_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign match_o = match_q;

endmodule

/* sv/csf_tally.sv */
module csf_tally #(
  parameter int unsigned LIST_MAX = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  csf_pkg::title_end_t      end_i,
  input  logic [csf_pkg::CapW-1:0] capacity_i,
  output csf_pkg::out_res_t        res_o
);
  import csf_pkg::*;

  localparam int unsigned TitleW   = (LIST_MAX > 2) ? $clog2(LIST_MAX) : 1;
  localparam int unsigned WideW    = 17;
  localparam int unsigned CapLimit = (LIST_MAX < 2047) ? LIST_MAX : 2047;

  logic [TitleW-1:0] title_q, title_d;
  logic [CapW-1:0]   kept_q, kept_d;
  logic [CapW-1:0]   cap_eff;
  logic [CapW-1:0]   kept_next;
  logic [WideW-1:0]  title_wide;
  logic              kept;

  assign cap_eff    = (capacity_i > CapW'(CapLimit)) ? CapW'(CapLimit) : capacity_i;
  assign kept       = end_i.matched && (kept_q < cap_eff);
  assign kept_next  = kept ? kept_q + CapW'(1) : kept_q;
  assign title_wide = WideW'(title_q);

  always_comb begin
    title_d = title_q;
    kept_d  = kept_q;
    if (end_i.fire) begin
      if (end_i.last) begin
        title_d = '0;
        kept_d  = '0;
      end else begin
        kept_d = kept_next;
        if (title_q == TitleW'(LIST_MAX - 1)) begin
          title_d = '0;
        end else begin
          title_d = title_q + TitleW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      title_q <= '0;
      kept_q  <= '0;
    end else begin
      title_q <= title_d;
      kept_q  <= kept_d;
    end
  end

  always_comb begin
    res_o.title_index   = title_wide[IndexW-1:0];
    res_o.title_matched = end_i.matched;
    res_o.title_kept    = kept;
    res_o.result_slot   = kept ? kept_q[IndexW-1:0] : '0;
    res_o.kept_total    = kept_next;
    res_o.list_done     = end_i.last;
    res_o.search_active = end_i.active;
  end

endmodule
